// File: sv/gst_pkg.sv
package gst_pkg;

   typedef enum logic [3:0] {
      MODE_DEF   = 4'd0,
      MODE_IDENT = 4'd1,
      MODE_NUM   = 4'd2,
      MODE_STR   = 4'd3,
      MODE_ARROW = 4'd4,
      MODE_SLASH = 4'd5,
      MODE_LCOM  = 4'd6,
      MODE_BCOM  = 4'd7,
      MODE_BSTAR = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_UNKNOWN = 2'd1,
      ERR_ARROW   = 2'd2,
      ERR_COMMENT = 2'd3
   } err_type;

   localparam logic [4:0] TYPE_IDENT  = 5'd0;
   localparam logic [4:0] TYPE_NUMBER = 5'd1;
   localparam logic [4:0] TYPE_STRING = 5'd2;
   localparam logic [4:0] TYPE_ARROW  = 5'd3;
   localparam logic [4:0] TYPE_SLASH  = 5'd4;
   localparam logic [4:0] TYPE_EOS    = 5'd25;
   // operator lookup returns this for a byte that is not an operator
   localparam logic [4:0] TYPE_NOT_OP = 5'd0;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   // results per word and result queue geometry
   localparam int MAX_RES     = 4;
   localparam int CNT_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      kind_type   kind;
      logic [4:0] ttype;
      logic [7:0] chr;
      err_type    err;
   } res_info_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [4:0] op_type(input logic [7:0] c);
      logic [4:0] t;
      unique case (c)
         8'h28:   t = 5'd5;
         8'h29:   t = 5'd6;
         8'h5B:   t = 5'd7;
         8'h5D:   t = 5'd8;
         8'h7B:   t = 5'd9;
         8'h7D:   t = 5'd10;
         8'h3D:   t = 5'd11;
         8'h3A:   t = 5'd12;
         8'h3B:   t = 5'd13;
         8'h2E:   t = 5'd14;
         8'h5E:   t = 5'd15;
         8'h24:   t = 5'd16;
         8'h2A:   t = 5'd17;
         8'h2B:   t = 5'd18;
         8'h3F:   t = 5'd19;
         8'h7C:   t = 5'd20;
         8'h2C:   t = 5'd21;
         8'h26:   t = 5'd22;
         8'h2D:   t = 5'd23;
         8'h40:   t = 5'd24;
         default: t = TYPE_NOT_OP;
      endcase
      return t;
   endfunction

   function automatic res_info_type mk_res(input kind_type k, input logic [4:0] t,
                                           input logic [7:0] c, input err_type e);
      res_info_type r;
      r.kind  = k;
      r.ttype = t;
      r.chr   = c;
      r.err   = e;
      return r;
   endfunction

endpackage

// File: sv/gst_front.sv
module gst_front
   import gst_pkg::*;
#(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16,
   parameter int BUNDLE_W    = CNT_W + MAX_RES * ($bits(res_info_type) + 36)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_value,
   input  logic                req_end_of_input,
   input  logic                q_full,
   output logic                q_push,
   output logic [BUNDLE_W-1:0] q_data
);

   localparam int RES_W = $bits(res_info_type) + LINE_BITS + COLUMN_BITS;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, sline_ff, sline_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, scol_ff, scol_in;
   logic [4:0]             ptype_ff, ptype_in;
   logic                   halt_ff, halt_in;

   logic                   take;
   logic [7:0]             c;
   logic [LINE_BITS-1:0]   nline;
   logic [COLUMN_BITS-1:0] ncol;
   logic [4:0]             opt;

   res_info_type           info [MAX_RES];
   logic [LINE_BITS-1:0]   rline [MAX_RES];
   logic [COLUMN_BITS-1:0] rcol [MAX_RES];
   logic [CNT_W-1:0]       n;
   logic                   dflt;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;
   assign c         = req_char_value;
   assign opt       = op_type(c);

   // position after this byte, saturating
   always_comb begin
      if (c == CH_NL) begin
         nline = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
         ncol  = '0;
      end else begin
         nline = line_ff;
         ncol  = (col_ff == COL_MAX) ? col_ff : col_ff + 1'b1;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      ptype_in = ptype_ff;
      halt_in  = halt_ff;
      n        = '0;
      dflt     = 1'b0;
      for (int i = 0; i < MAX_RES; i++) begin
         info[i]  = mk_res(KIND_CHAR, TYPE_IDENT, 8'h00, ERR_NONE);
         rline[i] = '0;
         rcol[i]  = '0;
      end

      if (take) begin
         if (req_end_of_input) begin
            mode_in = MODE_DEF;
            if (halt_ff) begin
               halt_in = 1'b0;
            end else begin
               unique case (mode_ff) inside
                  MODE_ARROW: begin
                     info[0]  = mk_res(KIND_ERROR, TYPE_IDENT, 8'h00, ERR_ARROW);
                     rline[0] = line_ff;
                     rcol[0]  = col_ff;
                     n        = 3'd1;
                  end
                  MODE_BCOM, MODE_BSTAR: begin
                     info[0]  = mk_res(KIND_ERROR, TYPE_IDENT, 8'h00, ERR_COMMENT);
                     rline[0] = sline_ff;
                     rcol[0]  = scol_ff;
                     n        = 3'd1;
                  end
                  default: begin
                     if (mode_ff == MODE_IDENT || mode_ff == MODE_NUM ||
                         mode_ff == MODE_STR) begin
                        info[n[1:0]]  = mk_res(KIND_END, ptype_ff, 8'h00, ERR_NONE);
                        rline[n[1:0]] = sline_ff;
                        rcol[n[1:0]]  = scol_ff;
                        n             = n + 1'b1;
                     end else if (mode_ff == MODE_SLASH) begin
                        ptype_in      = TYPE_SLASH;
                        info[n[1:0]]  = mk_res(KIND_CHAR, TYPE_SLASH, CH_SLASH, ERR_NONE);
                        rline[n[1:0]] = sline_ff;
                        rcol[n[1:0]]  = scol_ff;
                        n             = n + 1'b1;
                        info[n[1:0]]  = mk_res(KIND_END, TYPE_SLASH, 8'h00, ERR_NONE);
                        rline[n[1:0]] = sline_ff;
                        rcol[n[1:0]]  = scol_ff;
                        n             = n + 1'b1;
                     end
                     info[n[1:0]]  = mk_res(KIND_END, TYPE_EOS, 8'h00, ERR_NONE);
                     rline[n[1:0]] = sline_ff;
                     rcol[n[1:0]]  = scol_ff;
                     n             = n + 1'b1;
                  end
               endcase
            end
         end else if (!halt_ff) begin
            line_in = nline;
            col_in  = ncol;
            // first pass over the byte in the current mode
            unique case (mode_ff) inside
               MODE_IDENT, MODE_NUM: begin
                  if ((mode_ff == MODE_IDENT && (is_alpha(c) || is_digit(c) ||
                       c == CH_UNDER)) || (mode_ff == MODE_NUM && is_digit(c))) begin
                     info[0]  = mk_res(KIND_CHAR, ptype_ff, c, ERR_NONE);
                     rline[0] = sline_ff;
                     rcol[0]  = scol_ff;
                     n        = 3'd1;
                  end else begin
                     info[0]  = mk_res(KIND_END, ptype_ff, 8'h00, ERR_NONE);
                     rline[0] = sline_ff;
                     rcol[0]  = scol_ff;
                     n        = 3'd1;
                     mode_in  = MODE_DEF;
                     dflt     = 1'b1;
                  end
               end
               MODE_STR: begin
                  info[0]  = (c != CH_QUOTE) ? mk_res(KIND_CHAR, ptype_ff, c, ERR_NONE)
                                             : mk_res(KIND_END, ptype_ff, 8'h00, ERR_NONE);
                  rline[0] = sline_ff;
                  rcol[0]  = scol_ff;
                  n        = 3'd1;
                  if (c == CH_QUOTE) begin
                     mode_in = MODE_DEF;
                  end
               end
               MODE_ARROW: begin
                  mode_in = MODE_DEF;
                  if (c == CH_DASH) begin
                     ptype_in = TYPE_ARROW;
                     info[0]  = mk_res(KIND_CHAR, TYPE_ARROW, CH_LT, ERR_NONE);
                     info[1]  = mk_res(KIND_CHAR, TYPE_ARROW, CH_DASH, ERR_NONE);
                     info[2]  = mk_res(KIND_END, TYPE_ARROW, 8'h00, ERR_NONE);
                     for (int i = 0; i < 3; i++) begin
                        rline[i] = sline_ff;
                        rcol[i]  = scol_ff;
                     end
                     n = 3'd3;
                  end else begin
                     info[0]  = mk_res(KIND_ERROR, TYPE_IDENT, 8'h00, ERR_ARROW);
                     rline[0] = nline;
                     rcol[0]  = ncol;
                     n        = 3'd1;
                     halt_in  = 1'b1;
                  end
               end
               MODE_SLASH: begin
                  if (c == CH_SLASH) begin
                     mode_in = MODE_LCOM;
                  end else if (c == CH_STAR) begin
                     mode_in = MODE_BCOM;
                  end else begin
                     // lone slash: emit it, then run this byte again from default
                     ptype_in = TYPE_SLASH;
                     info[0]  = mk_res(KIND_CHAR, TYPE_SLASH, CH_SLASH, ERR_NONE);
                     info[1]  = mk_res(KIND_END, TYPE_SLASH, 8'h00, ERR_NONE);
                     rline[0] = sline_ff;
                     rcol[0]  = scol_ff;
                     rline[1] = sline_ff;
                     rcol[1]  = scol_ff;
                     n        = 3'd2;
                     mode_in  = MODE_DEF;
                     dflt     = 1'b1;
                  end
               end
               MODE_LCOM: begin
                  if (c == CH_NL) begin
                     mode_in = MODE_DEF;
                  end
               end
               MODE_BCOM: begin
                  if (c == CH_STAR) begin
                     mode_in = MODE_BSTAR;
                  end
               end
               MODE_BSTAR: begin
                  mode_in = (c == CH_SLASH) ? MODE_DEF : MODE_BCOM;
               end
               default: begin
                  mode_in = MODE_DEF;
                  dflt    = 1'b1;
               end
            endcase

            // default-mode handling of the byte
            if (dflt && !is_space(c)) begin
               sline_in = nline;
               scol_in  = ncol;
               if (is_alpha(c)) begin
                  mode_in       = MODE_IDENT;
                  ptype_in      = TYPE_IDENT;
                  info[n[1:0]]  = mk_res(KIND_CHAR, TYPE_IDENT, c, ERR_NONE);
                  rline[n[1:0]] = nline;
                  rcol[n[1:0]]  = ncol;
                  n             = n + 1'b1;
               end else if (is_digit(c) || c == CH_UNDER) begin
                  mode_in       = MODE_NUM;
                  ptype_in      = TYPE_NUMBER;
                  info[n[1:0]]  = mk_res(KIND_CHAR, TYPE_NUMBER, c, ERR_NONE);
                  rline[n[1:0]] = nline;
                  rcol[n[1:0]]  = ncol;
                  n             = n + 1'b1;
               end else if (c == CH_QUOTE) begin
                  mode_in  = MODE_STR;
                  ptype_in = TYPE_STRING;
               end else if (c == CH_LT) begin
                  mode_in  = MODE_ARROW;
                  ptype_in = TYPE_ARROW;
               end else if (c == CH_SLASH) begin
                  mode_in  = MODE_SLASH;
                  ptype_in = TYPE_SLASH;
               end else if (opt == TYPE_NOT_OP) begin
                  info[n[1:0]]  = mk_res(KIND_ERROR, TYPE_IDENT, c, ERR_UNKNOWN);
                  rline[n[1:0]] = nline;
                  rcol[n[1:0]]  = ncol;
                  n             = n + 1'b1;
                  halt_in       = 1'b1;
                  mode_in       = MODE_DEF;
               end else begin
                  ptype_in      = opt;
                  info[n[1:0]]  = mk_res(KIND_CHAR, opt, c, ERR_NONE);
                  rline[n[1:0]] = nline;
                  rcol[n[1:0]]  = ncol;
                  n             = n + 1'b1;
                  info[n[1:0]]  = mk_res(KIND_END, opt, 8'h00, ERR_NONE);
                  rline[n[1:0]] = nline;
                  rcol[n[1:0]]  = ncol;
                  n             = n + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      q_data = '0;
      q_data[CNT_W-1:0] = n;
      for (int i = 0; i < MAX_RES; i++) begin
         q_data[CNT_W + i*RES_W +: RES_W] = {info[i], rline[i], rcol[i]};
      end
   end

   assign q_push = take && (n != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_DEF;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= '0;
         sline_ff <= LINE_BITS'(1);
         scol_ff  <= '0;
         ptype_ff <= TYPE_IDENT;
         halt_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         ptype_ff <= ptype_in;
         halt_ff  <= halt_in;
      end
   end

endmodule

// File: sv/gst_queue.sv
module gst_queue
   import gst_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ff];
   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty     = (cnt_ff == '0);

endmodule

// File: sv/gst_back.sv
module gst_back
   import gst_pkg::*;
#(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16,
   parameter int BUNDLE_W    = CNT_W + MAX_RES * ($bits(res_info_type) + 36)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  logic [BUNDLE_W-1:0]    q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_result_kind,
   output logic [4:0]             rsp_token_type,
   output logic [7:0]             rsp_token_char,
   output logic [LINE_BITS-1:0]   rsp_token_line,
   output logic [COLUMN_BITS-1:0] rsp_token_column,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last_of_run
);

   localparam int RES_W  = $bits(res_info_type) + LINE_BITS + COLUMN_BITS;
   localparam int INFO_W = $bits(res_info_type);

   logic [1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0] cnt;
   logic [RES_W-1:0] entry;
   res_info_type     info;
   logic             last;
   logic             fire;

   assign cnt   = q_head[CNT_W-1:0];
   assign entry = q_head[CNT_W + idx_ff*RES_W +: RES_W];
   assign info  = res_info_type'(entry[RES_W-1 -: INFO_W]);
   assign last  = ({1'b0, idx_ff} == cnt - 1'b1);
   assign fire  = rsp_valid && !rsp_stall;

   assign rsp_valid        = !q_empty;
   assign rsp_result_kind  = info.kind;
   assign rsp_token_type   = info.ttype;
   assign rsp_token_char   = info.chr;
   assign rsp_error_code   = info.err;
   assign rsp_token_line   = entry[COLUMN_BITS +: LINE_BITS];
   assign rsp_token_column = entry[COLUMN_BITS-1:0];
   assign rsp_last_of_run  = last;
   assign q_pop            = fire && last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: sv/grammar_source_tokenizer_unit.sv
// Source tokenizer: takes one byte (or an end marker) per req word and emits token
// characters, token ends and errors as rsp words. The lexer front end takes a byte
// every cycle while the queue is not full and turns it into a group of zero to four
// results in the same cycle; groups go through a four-deep queue to the back end,
// which sends one result per cycle while rsp_stall is low. Sustained input rate
// is one byte per cycle as long as bytes average no more than one result each and
// rsp_stall stays low; a byte that yields k results holds the output until all k
// are sent; req_stall rises only when four groups wait. No clearing pass after reset.
module grammar_source_tokenizer_unit
   import gst_pkg::*;
#(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_value,
   input  logic                   req_end_of_input,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_result_kind,
   output logic [4:0]             rsp_token_type,
   output logic [7:0]             rsp_token_char,
   output logic [LINE_BITS-1:0]   rsp_token_line,
   output logic [COLUMN_BITS-1:0] rsp_token_column,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last_of_run
);

   localparam int RES_W    = $bits(res_info_type) + LINE_BITS + COLUMN_BITS;
   localparam int BUNDLE_W = CNT_W + MAX_RES * RES_W;

   logic                q_push, q_pop, q_full, q_empty;
   logic [BUNDLE_W-1:0] q_data, q_head;

   gst_front #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .BUNDLE_W    (BUNDLE_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_value   (req_char_value),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_data)
   );

   gst_queue #(
      .WIDTH (BUNDLE_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_data (q_head)
   );

   gst_back #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .BUNDLE_W    (BUNDLE_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_token_type   (rsp_token_type),
      .rsp_token_char   (rsp_token_char),
      .rsp_token_line   (rsp_token_line),
      .rsp_token_column (rsp_token_column),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
